@@ src/cc_pkg.sv @@
`timescale 1ns / 1ps
package cc_pkg;

	localparam int NUM_KINDS      = 7;
	localparam int KIND_W         = 3;
	localparam int DEN_W          = 14;
	localparam int RECIP_W        = 17;
	localparam int RECIP_SHIFT    = 20;
	localparam int CREDIT_W       = 20;
	localparam int AMOUNT_W       = 17;
	localparam int PRICE_W        = 17;
	localparam int QUO_W          = 17;
	localparam int OUT_W          = 16;
	localparam int STOCK_BITS_DEF = 16;

	localparam logic [CREDIT_W-1:0] CREDIT_LIMIT = 20'd999990;

	localparam logic [KIND_W-1:0] KIND_FIRST = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LAST  = 3'd6;
	localparam logic [KIND_W-1:0] KIND_NONE  = 3'd7;

	localparam logic [1:0] ITEM_FIRST  = 2'd0;
	localparam logic [1:0] ITEM_SECOND = 2'd1;
	localparam logic [1:0] ITEM_THIRD  = 2'd2;
	localparam logic [1:0] ITEM_NONE   = 2'd3;

	localparam logic [1:0] CFG_PRICE_FIRST  = 2'd0;
	localparam logic [1:0] CFG_PRICE_SECOND = 2'd1;
	localparam logic [1:0] CFG_PRICE_THIRD  = 2'd2;

	localparam logic [PRICE_W-1:0] PRICE_FIRST_RST  = 17'd1050;
	localparam logic [PRICE_W-1:0] PRICE_SECOND_RST = 17'd1240;
	localparam logic [PRICE_W-1:0] PRICE_THIRD_RST  = 17'd800;

	// denominations, largest first
	localparam logic [DEN_W-1:0] DEN [NUM_KINDS] = '{
		14'd10000, 14'd5000, 14'd1000, 14'd500, 14'd100, 14'd50, 14'd10
	};

	// floor(2^RECIP_SHIFT / DEN[k])
	localparam logic [RECIP_W-1:0] RECIP [NUM_KINDS] = '{
		17'd104, 17'd209, 17'd1048, 17'd2097, 17'd10485, 17'd20971, 17'd104857
	};

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_SELECT,
		CMD_RETURN,
		CMD_REFILL
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SMALL_AMOUNT,
		ST_CREDIT_LIMIT,
		ST_NO_ITEM,
		ST_SHORT_CREDIT,
		ST_CHANGE_SHORT
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RND_GO,
		S_RND_WAIT,
		S_INS_CHK,
		S_SEL,
		S_PAY_INIT,
		S_DIV_GO,
		S_DIV_WAIT,
		S_APPLY,
		S_PAY_SUB,
		S_PAY_END,
		S_CM_RD,
		S_CM_WR,
		S_REF_RD,
		S_REF_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_res_t;

endpackage

@@ src/coin_changer_with_inventory.sv @@
`timescale 1ns / 1ps
// Coin changer: one command word at a time, taken when start is high and busy is low.
// Each command yields one result word, shown for exactly one cycle with done high;
// the receiver cannot stall it. Busy time per command is set by one shared
// constant divider and the stock memory walk over seven denominations: refill
// skips the memory when the kind matches none, insert skips the walk when
// rejected, return skips the stock commit when change is short, and select adds
// a price check before return. Price writes on the wr_ port are taken at any edge.
module coin_changer_with_inventory import cc_pkg::*; #(
	parameter int STOCK_BITS = STOCK_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          command,
	input  logic [AMOUNT_W-1:0] amount,
	input  logic [1:0]          item,
	input  logic [KIND_W-1:0]   coin_kind,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [PRICE_W-1:0]  wr_data,
	output logic                done,
	output logic [2:0]          status,
	output logic                change_failed,
	output logic [CREDIT_W-1:0] credit,
	output logic [OUT_W-1:0]    out_10000,
	output logic [OUT_W-1:0]    out_5000,
	output logic [OUT_W-1:0]    out_1000,
	output logic [OUT_W-1:0]    out_500,
	output logic [OUT_W-1:0]    out_100,
	output logic [OUT_W-1:0]    out_50,
	output logic [OUT_W-1:0]    out_10
);

	localparam int SUM_W = ((STOCK_BITS > QUO_W) ? STOCK_BITS : QUO_W) + 1;
	localparam logic [STOCK_BITS-1:0] STOCK_MAX = {STOCK_BITS{1'b1}};

	state_t              state_q;
	state_t              state_d;
	cmd_t                op_q;
	status_t             status_q;
	logic                failed_q;
	logic                paid_q;
	logic [KIND_W-1:0]   k_q;
	logic [CREDIT_W-1:0] credit_q;
	logic [PRICE_W-1:0]  price_first_q;
	logic [PRICE_W-1:0]  price_second_q;
	logic [PRICE_W-1:0]  price_third_q;
	logic [AMOUNT_W-1:0] amount_q;
	logic [1:0]          item_q;
	logic [CREDIT_W-1:0] rem_q;
	logic [QUO_W-1:0]    q_q;
	logic [DEN_W-1:0]    r_q;
	logic [QUO_W-1:0]    take_q [NUM_KINDS];
	logic [CREDIT_W-1:0] tprod_q;

	logic                  div_go;
	div_res_t              div_res;
	logic                  mem_we;
	logic [STOCK_BITS-1:0] mem_wdata;
	logic [STOCK_BITS-1:0] stock_rd;
	logic [QUO_W-1:0]      addend;
	logic [SUM_W-1:0]      sum;
	logic [STOCK_BITS-1:0] sat;
	logic [QUO_W-1:0]      take;
	logic [STOCK_BITS-1:0] left;
	logic [CREDIT_W:0]     credit_sum;
	logic [PRICE_W-1:0]    price;

	cc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (rem_q),
		.idx      (k_q),
		.res      (div_res)
	);

	cc_stock_mem #(
		.WIDTH (STOCK_BITS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (k_q),
		.wdata  (mem_wdata),
		.raddr  (k_q),
		.rdata  (stock_rd)
	);

	assign addend     = (op_q == CMD_REFILL) ? amount_q : q_q;
	assign sum        = SUM_W'(stock_rd) + SUM_W'(addend);
	assign sat        = (sum > SUM_W'(STOCK_MAX)) ? STOCK_MAX : STOCK_BITS'(sum);
	assign take       = (SUM_W'(stock_rd) < SUM_W'(q_q)) ? QUO_W'(stock_rd) : q_q;
	assign left       = stock_rd - STOCK_BITS'(take_q[k_q]);
	assign credit_sum = {1'b0, credit_q} + (CREDIT_W + 1)'(rem_q);

	always_comb begin
		unique case (item_q)
			ITEM_FIRST:  price = price_first_q;
			ITEM_SECOND: price = price_second_q;
			ITEM_THIRD:  price = price_third_q;
			default:     price = price_third_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (command)
						CMD_INSERT: state_d = S_RND_GO;
						CMD_SELECT: state_d = S_SEL;
						CMD_RETURN: state_d = S_PAY_INIT;
						default:    state_d = (coin_kind == KIND_NONE) ? S_DONE : S_REF_RD;
					endcase
				end
			end
			S_RND_GO:   state_d = S_RND_WAIT;
			S_RND_WAIT: if (div_res.done) state_d = S_INS_CHK;
			S_INS_CHK: begin
				if (rem_q == '0 || credit_sum > (CREDIT_W + 1)'(CREDIT_LIMIT)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_DIV_GO;
				end
			end
			S_SEL:      state_d = S_PAY_INIT;
			S_PAY_INIT: state_d = S_DIV_GO;
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT: if (div_res.done) state_d = S_APPLY;
			S_APPLY: begin
				if (op_q == CMD_INSERT) begin
					state_d = (k_q == KIND_LAST) ? S_DONE : S_DIV_GO;
				end else begin
					state_d = S_PAY_SUB;
				end
			end
			S_PAY_SUB:  state_d = (k_q == KIND_LAST) ? S_PAY_END : S_DIV_GO;
			S_PAY_END:  state_d = (rem_q == '0) ? S_CM_RD : S_DONE;
			S_CM_RD:    state_d = S_CM_WR;
			S_CM_WR:    state_d = (k_q == KIND_LAST) ? S_DONE : S_CM_RD;
			S_REF_RD:   state_d = S_REF_WR;
			S_REF_WR:   state_d = S_DONE;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != S_IDLE);
		done      = 1'b0;
		div_go    = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = sat;
		unique case (state_q)
			S_RND_GO: div_go = 1'b1;
			S_DIV_GO: div_go = 1'b1;
			S_APPLY:  mem_we = (op_q == CMD_INSERT);
			S_REF_WR: mem_we = 1'b1;
			S_CM_WR: begin
				mem_we    = 1'b1;
				mem_wdata = left;
			end
			S_DONE:   done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			status_q       <= ST_OK;
			failed_q       <= 1'b0;
			paid_q         <= 1'b0;
			k_q            <= KIND_FIRST;
			credit_q       <= '0;
			price_first_q  <= PRICE_FIRST_RST;
			price_second_q <= PRICE_SECOND_RST;
			price_third_q  <= PRICE_THIRD_RST;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (wr_index)
					CFG_PRICE_FIRST:  price_first_q  <= wr_data;
					CFG_PRICE_SECOND: price_second_q <= wr_data;
					CFG_PRICE_THIRD:  price_third_q  <= wr_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= ST_OK;
						failed_q <= 1'b0;
						paid_q   <= 1'b0;
						k_q      <= (command == CMD_INSERT) ? KIND_LAST : coin_kind;
					end
				end
				S_INS_CHK: begin
					if (rem_q == '0) begin
						status_q <= ST_SMALL_AMOUNT;
					end else if (credit_sum > (CREDIT_W + 1)'(CREDIT_LIMIT)) begin
						status_q <= ST_CREDIT_LIMIT;
					end else begin
						credit_q <= credit_q + rem_q;
						k_q      <= KIND_FIRST;
					end
				end
				S_SEL: begin
					if (item_q == ITEM_NONE) begin
						status_q <= ST_NO_ITEM;
					end else if (credit_q >= CREDIT_W'(price)) begin
						credit_q <= credit_q - CREDIT_W'(price);
					end else begin
						status_q <= ST_SHORT_CREDIT;
					end
				end
				S_PAY_INIT: k_q <= KIND_FIRST;
				S_APPLY: begin
					if (op_q == CMD_INSERT && k_q != KIND_LAST) begin
						k_q <= k_q + 1'b1;
					end
				end
				S_PAY_SUB: if (k_q != KIND_LAST) k_q <= k_q + 1'b1;
				S_PAY_END: begin
					if (rem_q == '0) begin
						credit_q <= '0;
						paid_q   <= 1'b1;
						k_q      <= KIND_FIRST;
					end else begin
						failed_q <= 1'b1;
						if (status_q == ST_OK) begin
							status_q <= ST_CHANGE_SHORT;
						end
					end
				end
				S_CM_WR: if (k_q != KIND_LAST) k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q     <= cmd_t'(command);
					amount_q <= amount;
					item_q   <= item;
					rem_q    <= CREDIT_W'(amount);
				end
			end
			S_RND_WAIT: if (div_res.done) rem_q <= rem_q - CREDIT_W'(div_res.rem);
			S_PAY_INIT: rem_q <= credit_q;
			S_DIV_WAIT: begin
				if (div_res.done) begin
					q_q <= div_res.quo;
					r_q <= div_res.rem;
				end
			end
			S_APPLY: begin
				if (op_q == CMD_INSERT) begin
					rem_q <= CREDIT_W'(r_q);
				end else begin
					take_q[k_q] <= take;
					tprod_q     <= CREDIT_W'(take) * CREDIT_W'(DEN[k_q]);
				end
			end
			S_PAY_SUB: rem_q <= rem_q - tprod_q;
			default: ;
		endcase
	end

	assign status        = status_q;
	assign change_failed = failed_q;
	assign credit        = credit_q;
	assign out_10000     = paid_q ? take_q[0][OUT_W-1:0] : '0;
	assign out_5000      = paid_q ? take_q[1][OUT_W-1:0] : '0;
	assign out_1000      = paid_q ? take_q[2][OUT_W-1:0] : '0;
	assign out_500       = paid_q ? take_q[3][OUT_W-1:0] : '0;
	assign out_100       = paid_q ? take_q[4][OUT_W-1:0] : '0;
	assign out_50        = paid_q ? take_q[5][OUT_W-1:0] : '0;
	assign out_10        = paid_q ? take_q[6][OUT_W-1:0] : '0;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("result word without a command in progress");

	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && change_failed) |-> (status_q == ST_CHANGE_SHORT ||
			status_q == ST_NO_ITEM || status_q == ST_SHORT_CREDIT))
		else $error("failed payout with inconsistent status");

	a_commit_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CM_WR) |-> (SUM_W'(stock_rd) >= SUM_W'(take_q[k_q])))
		else $error("payout commit takes more coins than stocked");

	a_div_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_DIV_WAIT || state_q == S_RND_WAIT))
		else $error("divider result outside a wait state");

endmodule

@@ src/cc_stock_mem.sv @@
`timescale 1ns / 1ps
module cc_stock_mem import cc_pkg::*; #(
	parameter int WIDTH = STOCK_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [KIND_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [KIND_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0]     mem_q [NUM_KINDS];
	logic [NUM_KINDS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk) begin
		rdata <= valid_q[raddr] ? mem_q[raddr] : '0;
	end

endmodule

@@ src/cc_div.sv @@
`timescale 1ns / 1ps
module cc_div import cc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [CREDIT_W-1:0] dividend,
	input  logic [KIND_W-1:0]   idx,
	output div_res_t            res
);

	localparam int PROD_W = CREDIT_W + RECIP_W;

	logic                v_s1;
	logic                v_s2;
	logic                done_s3;
	logic [PROD_W-1:0]   prod_s1;
	logic [CREDIT_W-1:0] dvd_s1;
	logic [CREDIT_W-1:0] dvd_s2;
	logic [KIND_W-1:0]   idx_s1;
	logic [KIND_W-1:0]   idx_s2;
	logic [QUO_W-1:0]    q0_s2;
	logic [CREDIT_W-1:0] qd_s2;
	logic [QUO_W-1:0]    quo_s3;
	logic [DEN_W-1:0]    rem_s3;
	logic [QUO_W-1:0]    q0;
	logic [CREDIT_W-1:0] r0;
	logic [CREDIT_W-1:0] den2;

	assign q0   = prod_s1[RECIP_SHIFT +: QUO_W];
	assign r0   = dvd_s2 - qd_s2;
	assign den2 = CREDIT_W'(DEN[idx_s2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= go;
			v_s2    <= v_s1;
			done_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(dividend) * PROD_W'(RECIP[idx]);
		dvd_s1  <= dividend;
		idx_s1  <= idx;
		q0_s2   <= q0;
		qd_s2   <= CREDIT_W'(q0) * CREDIT_W'(DEN[idx_s1]);
		dvd_s2  <= dvd_s1;
		idx_s2  <= idx_s1;
		// estimate is low by at most one
		if (r0 >= den2) begin
			quo_s3 <= q0_s2 + 1'b1;
			rem_s3 <= DEN_W'(r0 - den2);
		end else begin
			quo_s3 <= q0_s2;
			rem_s3 <= DEN_W'(r0);
		end
	end

	assign res = '{done: done_s3, quo: quo_s3, rem: rem_s3};

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
	import cc_pkg::*;

	localparam int unsigned COIN_VAL [NUM_KINDS] = '{10000, 5000, 1000, 500, 100, 50, 10};
	localparam int unsigned STOCK_MAX = 65535;
	localparam int unsigned CREDIT_CAP = 999990;
	localparam int RUN_LIMIT = 1000000;
	localparam int DRAIN_WAIT = 80;
	localparam int DIRECTED_WORDS = 25;
	localparam int PHASE_WORDS = 240;

	typedef enum logic [1:0] {
		STEP_WORD,
		STEP_PRICE,
		STEP_HOLD
	} step_t;

	typedef struct {
		step_t               what;
		cmd_t                cmd;
		logic [AMOUNT_W-1:0] amt;
		logic [1:0]          sel;
		logic [KIND_W-1:0]   kind_idx;
		logic [1:0]          reg_idx;
		logic [PRICE_W-1:0]  reg_val;
	} entry_t;

	typedef struct {
		status_t                        st;
		logic                           fail;
		logic [CREDIT_W-1:0]            cred;
		logic [NUM_KINDS-1:0][OUT_W-1:0] coins;
	} outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          command = '0;
	logic [AMOUNT_W-1:0] amount = '0;
	logic [1:0]          item = '0;
	logic [KIND_W-1:0]   coin_kind = '0;
	logic                wr_en = 1'b0;
	logic [1:0]          wr_index = '0;
	logic [PRICE_W-1:0]  wr_data = '0;
	logic                done;
	logic [2:0]          status;
	logic                change_failed;
	logic [CREDIT_W-1:0] credit;
	logic [OUT_W-1:0]    out_10000;
	logic [OUT_W-1:0]    out_5000;
	logic [OUT_W-1:0]    out_1000;
	logic [OUT_W-1:0]    out_500;
	logic [OUT_W-1:0]    out_100;
	logic [OUT_W-1:0]    out_50;
	logic [OUT_W-1:0]    out_10;

	coin_changer_with_inventory i_dut (.*);

	entry_t   word_q [$];
	outcome_t outcome_q [$];

	int unsigned        stock [NUM_KINDS] = '{default: 0};
	int unsigned        held_credit = 0;
	logic [PRICE_W-1:0] price_of [3] = '{PRICE_FIRST_RST, PRICE_SECOND_RST, PRICE_THIRD_RST};

	int     mismatches = 0;
	int     words_done = 0;
	int     queued_words = 0;
	int     cycles = 0;
	int     idle_left = 0;
	int     calm_left = 0;
	int     idle_r;
	logic   go;
	logic   wr_go;
	entry_t cur_word;

	outcome_t                        want;
	logic [NUM_KINDS-1:0][OUT_W-1:0] got_coins;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag(string msg);
		$display("mismatch on word %0d at %0t: %s", words_done, $time, msg);
		mismatches++;
	endtask

	function automatic void stock_add(int k, int unsigned n);
		if (n > STOCK_MAX - stock[k])
			stock[k] = STOCK_MAX;
		else
			stock[k] += n;
	endfunction

	function automatic bit pay_credit(output logic [NUM_KINDS-1:0][OUT_W-1:0] coins);
		int unsigned rest;
		int unsigned need;
		int unsigned take [NUM_KINDS];
		coins = '0;
		rest = held_credit;
		for (int k = 0; k < NUM_KINDS; k++) begin
			need = rest / COIN_VAL[k];
			take[k] = (need < stock[k]) ? need : stock[k];
			rest -= take[k] * COIN_VAL[k];
		end
		if (rest != 0)
			return 1'b0;
		for (int k = 0; k < NUM_KINDS; k++) begin
			stock[k] -= take[k];
			coins[k] = OUT_W'(take[k]);
		end
		held_credit = 0;
		return 1'b1;
	endfunction

	function automatic outcome_t vend_outcome(entry_t w);
		outcome_t    o;
		int unsigned amt;
		int unsigned rest;
		int unsigned cost;
		o.st = ST_OK;
		o.fail = 1'b0;
		o.coins = '0;
		case (w.cmd)
			CMD_INSERT: begin
				amt = w.amt;
				amt = amt / 10 * 10;
				if (amt == 0) begin
					o.st = ST_SMALL_AMOUNT;
				end else if (held_credit + amt > CREDIT_CAP) begin
					o.st = ST_CREDIT_LIMIT;
				end else begin
					held_credit += amt;
					rest = amt;
					for (int k = 0; k < NUM_KINDS; k++) begin
						stock_add(k, rest / COIN_VAL[k]);
						rest = rest % COIN_VAL[k];
					end
				end
			end
			CMD_SELECT: begin
				if (w.sel == ITEM_NONE) begin
					o.st = ST_NO_ITEM;
				end else begin
					cost = price_of[w.sel];
					if (held_credit >= cost)
						held_credit -= cost;
					else
						o.st = ST_SHORT_CREDIT;
				end
				if (!pay_credit(o.coins)) begin
					o.fail = 1'b1;
					if (o.st == ST_OK)
						o.st = ST_CHANGE_SHORT;
				end
			end
			CMD_RETURN: begin
				if (!pay_credit(o.coins)) begin
					o.fail = 1'b1;
					o.st = ST_CHANGE_SHORT;
				end
			end
			default: begin
				if (w.kind_idx != KIND_NONE)
					stock_add(w.kind_idx, w.amt);
			end
		endcase
		o.cred = CREDIT_W'(held_credit);
		return o;
	endfunction

	// negative arguments draw the field at random
	task automatic add_word(cmd_t c, int amt, int sel, int kv);
		entry_t s;
		s.what = STEP_WORD;
		s.cmd = c;
		s.amt = AMOUNT_W'((amt < 0) ? $urandom_range(0, 99999) : amt);
		s.sel = 2'((sel < 0) ? $urandom_range(0, 3) : sel);
		s.kind_idx = KIND_W'((kv < 0) ? $urandom_range(0, 7) : kv);
		s.reg_idx = '0;
		s.reg_val = '0;
		word_q = {word_q, s};
		queued_words++;
	endtask

	task automatic add_price(logic [1:0] idx, int unsigned val);
		entry_t s;
		s = '{what: STEP_PRICE, cmd: CMD_INSERT, amt: '0, sel: '0, kind_idx: '0,
			reg_idx: idx, reg_val: PRICE_W'(val)};
		word_q = {word_q, s};
	endtask

	task automatic add_hold();
		entry_t s;
		s = '{what: STEP_HOLD, cmd: CMD_INSERT, amt: '0, sel: '0, kind_idx: '0,
			reg_idx: '0, reg_val: '0};
		word_q = {word_q, s};
	endtask

	task automatic add_session();
		int r;
		int n;
		int amt;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			add_word(cmd_t'($urandom_range(0, 3)), -1, -1, -1);
		end else if (r < 15) begin
			amt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 60);
			add_word(CMD_REFILL, amt, -1, $urandom_range(0, 7));
		end else if (r < 19) begin
			n = $urandom_range(9, 12);
			repeat (n) add_word(CMD_INSERT, $urandom_range(90000, 99999), -1, -1);
			add_word(CMD_SELECT, -1, $urandom_range(0, 3), -1);
		end else begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: amt = COIN_VAL[$urandom_range(0, NUM_KINDS - 1)];
					1: amt = COIN_VAL[$urandom_range(0, NUM_KINDS - 1)] * $urandom_range(1, 5);
					2: amt = $urandom_range(0, 9999);
					default: amt = $urandom_range(0, 99999);
				endcase
				add_word(CMD_INSERT, amt, -1, -1);
			end
			// abandon the purchase now and then
			if ($urandom_range(0, 9) == 0)
				return;
			if ($urandom_range(0, 3) == 0)
				add_word(CMD_RETURN, -1, -1, -1);
			else
				add_word(CMD_SELECT, -1,
					($urandom_range(0, 9) == 0) ? ITEM_NONE : $urandom_range(0, 2), -1);
		end
	endtask

	initial begin
		int unsigned p [3];

		add_word(CMD_RETURN, -1, -1, -1);
		add_word(CMD_INSERT, 9, -1, -1);
		add_word(CMD_INSERT, 0, -1, -1);
		add_word(CMD_INSERT, 99999, -1, -1);
		add_word(CMD_SELECT, -1, ITEM_NONE, -1);
		add_word(CMD_INSERT, 1000, -1, -1);
		add_word(CMD_SELECT, -1, ITEM_THIRD, -1);
		add_word(CMD_SELECT, -1, ITEM_FIRST, -1);
		add_word(CMD_REFILL, 99999, -1, KIND_NONE);
		add_word(CMD_REFILL, 2, -1, 4);
		add_word(CMD_RETURN, -1, -1, -1);
		add_word(CMD_REFILL, 99999, -1, KIND_LAST);
		repeat (10) add_word(CMD_INSERT, 99999, -1, -1);
		add_word(CMD_INSERT, 99999, -1, -1);
		add_word(CMD_INSERT, 90, -1, -1);
		add_word(CMD_SELECT, -1, ITEM_SECOND, -1);

		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < 3; i++) begin
				case (ph)
					0: p[i] = 10;
					1: p[i] = 99990;
					default: p[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 99990)
						: 10 * $urandom_range(1, 300);
				endcase
			end
			add_price(CFG_PRICE_FIRST, p[0]);
			add_price(CFG_PRICE_SECOND, p[1]);
			add_price(CFG_PRICE_THIRD, p[2]);
			while (queued_words < DIRECTED_WORDS + ph * PHASE_WORDS + PHASE_WORDS / 2)
				add_session();
			add_hold();
			while (queued_words < DIRECTED_WORDS + (ph + 1) * PHASE_WORDS)
				add_session();
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (word_q.size() != 0 || outcome_q.size() != 0 || start || busy)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			wr_en <= 1'b0;
			idle_left = 0;
		end else begin
			go = start;
			wr_go = 1'b0;
			if (start && !busy) begin
				outcome_q = {outcome_q, vend_outcome(cur_word)};
				go = 1'b0;
				idle_r = $urandom_range(0, 99);
				if (calm_left > 0) begin
					calm_left--;
					idle_left = 0;
				end else if (idle_r < 2) begin
					calm_left = $urandom_range(20, 40);
					idle_left = 0;
				end else if (idle_r < 40) begin
					idle_left = 0;
				end else if (idle_r < 85) begin
					idle_left = $urandom_range(1, 3);
				end else if (idle_r < 97) begin
					idle_left = $urandom_range(4, 15);
				end else begin
					idle_left = $urandom_range(20, 60);
				end
			end
			if (!go && word_q.size() != 0) begin
				if (word_q[0].what == STEP_WORD) begin
					if (idle_left > 0) begin
						idle_left--;
					end else begin
						cur_word = word_q.pop_front();
						go = 1'b1;
						command <= cur_word.cmd;
						amount <= cur_word.amt;
						item <= cur_word.sel;
						coin_kind <= cur_word.kind_idx;
					end
				end else if (outcome_q.size() == 0 && !done && !busy && !start) begin
					// block is idle: price writes and holds may go through
					if (word_q[0].what == STEP_PRICE) begin
						wr_go = 1'b1;
						wr_index <= word_q[0].reg_idx;
						wr_data <= word_q[0].reg_val;
						price_of[word_q[0].reg_idx] = word_q[0].reg_val;
					end
					void'(word_q.pop_front());
				end
			end
			start <= go;
			wr_en <= wr_go;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			words_done++;
			if (outcome_q.size() == 0) begin
				flag("result word with no command pending");
			end else begin
				want = outcome_q.pop_front();
				got_coins = {out_10, out_50, out_100, out_500, out_1000, out_5000, out_10000};
				if (status !== want.st)
					flag($sformatf("status got %0d expected %0d", status, want.st));
				if (change_failed !== want.fail)
					flag($sformatf("change_failed got %0b expected %0b", change_failed,
						want.fail));
				if (credit !== want.cred)
					flag($sformatf("credit got %0d expected %0d", credit, want.cred));
				for (int k = 0; k < NUM_KINDS; k++) begin
					if (got_coins[k] !== want.coins[k])
						flag($sformatf("out_%0d got %0d expected %0d", COIN_VAL[k],
							got_coins[k], want.coins[k]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
